### rtl/set_union_intersection_defines.svh
// ============================================================================
// set_union_intersection_defines
// Assertion macros shared by the set union and intersection block.
// ============================================================================
`ifndef SET_UNION_INTERSECTION_DEFINES_SVH
`define SET_UNION_INTERSECTION_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SUI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SUI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sui_pkg.sv
// ============================================================================
// sui_pkg
// Types and constants shared by the set union and intersection modules.
// ============================================================================
package sui_pkg;

    localparam int VALUE_W    = 32;
    localparam int ACTION_W   = 2;
    localparam int OUT_USER_W = 3;

    localparam logic [ACTION_W-1:0] ACT_APP_A = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APP_B = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RUN   = 2'd2;

    typedef enum logic [1:0] {
        OSEL_CAND = 2'd0,
        OSEL_PEND = 2'd1,
        OSEL_ZERO = 2'd2
    } t_osel;

    typedef struct packed {
        logic  app_a;
        logic  app_b;
        logic  src_b;
        logic  fetch;
        logic  cand_ld;
        logic  scan_start;
        logic  scan;
        logic  pend_ld;
        logic  out_ld;
        t_osel out_sel;
        logic  out_kind;
        logic  out_empty;
        logic  out_last;
        logic  run_end;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic hit_a;
        logic hit_b;
        logic out_free;
    } t_sts;

endpackage

### rtl/sui_dp.sv
// ============================================================================
// sui_dp
// Datapath: list memories and counts, membership scan, result register.
// ============================================================================
`include "set_union_intersection_defines.svh"

module sui_dp import sui_pkg::*; #(
    parameter int CAPACITY = 16,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic [CW-1:0]             i_idx,
    input  logic [CW-1:0]             i_lim_a,
    input  logic [CW-1:0]             i_lim_b,
    input  logic signed [VALUE_W-1:0] i_value,
    output t_sts                      o_sts,
    output logic [CW-1:0]             o_cnt_a,
    output logic [CW-1:0]             o_cnt_b,
    input  logic                      i_m_tready,
    output logic                      o_m_tvalid,
    output logic [VALUE_W-1:0]        o_m_tdata,  // item_value
    output logic [OUT_USER_W-1:0]     o_m_tuser,  // set_kind, set_empty, dropped
    output logic                      o_m_tlast
);

    logic signed [VALUE_W-1:0] r_mem_a [CAPACITY];
    logic signed [VALUE_W-1:0] r_mem_b [CAPACITY];
    logic signed [VALUE_W-1:0] r_rd_a;
    logic signed [VALUE_W-1:0] r_rd_b;
    logic signed [VALUE_W-1:0] r_cand;
    logic signed [VALUE_W-1:0] r_pend;
    logic [CW-1:0]             r_cnt_a;
    logic [CW-1:0]             r_cnt_b;
    logic                      r_ovf;
    logic [CW-1:0]             r_k;
    logic [CW-1:0]             r_cmp_k;
    logic                      r_cmp_vld;
    logic [CW-1:0]             r_lim_a;
    logic [CW-1:0]             r_lim_b;
    logic [CW-1:0]             r_lim_m;
    logic                      r_hit_a;
    logic                      r_hit_b;
    logic                      r_out_vld;
    logic signed [VALUE_W-1:0] r_out_val;
    logic                      r_out_kind;
    logic                      r_out_empty;
    logic                      r_out_drop;
    logic                      r_out_last;
    logic [AW-1:0]             rd_addr;
    logic                      full_a;
    logic                      full_b;
    logic                      out_free;

    assign full_a   = (r_cnt_a == CW'(CAPACITY));
    assign full_b   = (r_cnt_b == CW'(CAPACITY));
    assign rd_addr  = i_cmd.fetch ? i_idx[AW-1:0] : r_k[AW-1:0];
    assign out_free = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.app_a && !full_a) begin
            r_mem_a[r_cnt_a[AW-1:0]] <= i_value;
        end
        if (i_cmd.app_b && !full_b) begin
            r_mem_b[r_cnt_b[AW-1:0]] <= i_value;
        end
        r_rd_a <= r_mem_a[rd_addr];
        r_rd_b <= r_mem_b[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.run_end) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.app_a) begin
                if (full_a) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_cnt_a <= r_cnt_a + CW'(1);
                end
            end
            if (i_cmd.app_b) begin
                if (full_b) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_cnt_b <= r_cnt_b + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.scan) begin
            r_cmp_vld <= (r_k < r_lim_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_k     <= '0;
            r_lim_a <= i_lim_a;
            r_lim_b <= i_lim_b;
            r_lim_m <= (i_lim_a > i_lim_b) ? i_lim_a : i_lim_b;
            r_hit_a <= 1'b0;
            r_hit_b <= 1'b0;
        end else begin
            if (i_cmd.scan && (r_k < r_lim_m)) begin
                r_cmp_k <= r_k;
                r_k     <= r_k + CW'(1);
            end
            if (r_cmp_vld && (r_cmp_k < r_lim_a) && (r_rd_a == r_cand)) begin
                r_hit_a <= 1'b1;
            end
            if (r_cmp_vld && (r_cmp_k < r_lim_b) && (r_rd_b == r_cand)) begin
                r_hit_b <= 1'b1;
            end
        end
        if (i_cmd.cand_ld) begin
            r_cand <= i_cmd.src_b ? r_rd_b : r_rd_a;
        end
        if (i_cmd.pend_ld) begin
            r_pend <= r_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            case (i_cmd.out_sel)
                OSEL_CAND: r_out_val <= r_cand;
                OSEL_PEND: r_out_val <= r_pend;
                default:   r_out_val <= '0;
            endcase
            r_out_kind  <= i_cmd.out_kind;
            r_out_empty <= i_cmd.out_empty;
            r_out_drop  <= r_ovf;
            r_out_last  <= i_cmd.out_last;
        end
    end

    assign o_sts.scan_done = !r_cmp_vld && (r_k >= r_lim_m);
    assign o_sts.hit_a     = r_hit_a;
    assign o_sts.hit_b     = r_hit_b;
    assign o_sts.out_free  = out_free;
    assign o_cnt_a         = r_cnt_a;
    assign o_cnt_b         = r_cnt_b;
    assign o_m_tvalid      = r_out_vld;
    assign o_m_tdata       = r_out_val;
    assign o_m_tuser       = {r_out_drop, r_out_empty, r_out_kind};
    assign o_m_tlast       = r_out_last;

    `SUI_ASSERT_SAME(a_cnt_range, 1'b1, (r_cnt_a <= CW'(CAPACITY)) && (r_cnt_b <= CW'(CAPACITY)), "list count above capacity")
    `SUI_ASSERT_SAME(a_load_free, i_cmd.out_ld, out_free, "result loaded over a waiting result")
    `SUI_ASSERT_NEXT(a_run_clear, i_cmd.run_end, (r_cnt_a == '0) && (r_cnt_b == '0) && !r_ovf, "lists not cleared after run")

endmodule

### rtl/sui_ctrl.sv
// ============================================================================
// sui_ctrl
// Controller: takes appends, sequences the union and intersection passes.
// ============================================================================
`include "set_union_intersection_defines.svh"

module sui_ctrl import sui_pkg::*; #(
    parameter int CAPACITY = 16,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic [ACTION_W-1:0] i_action,
    output logic                o_s_tready,
    output t_cmd                o_cmd,
    input  t_sts                i_sts,
    input  logic [CW-1:0]       i_cnt_a,
    input  logic [CW-1:0]       i_cnt_b,
    output logic [CW-1:0]       o_idx,
    output logic [CW-1:0]       o_lim_a,
    output logic [CW-1:0]       o_lim_b
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_NEXT  = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_CAND  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;
    localparam logic [2:0] ST_UMARK = 3'd6;
    localparam logic [2:0] ST_IFIN  = 3'd7;

    localparam logic [1:0] PH_UA = 2'd0;
    localparam logic [1:0] PH_UB = 2'd1;
    localparam logic [1:0] PH_IN = 2'd2;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [1:0]    r_phase;
    logic [1:0]    n_phase;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] n_idx;
    logic          r_pend_vld;
    logic          n_pend_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_phase    <= PH_UA;
            r_idx      <= '0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_pend_vld <= n_pend_vld;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_idx         = r_idx;
        n_pend_vld    = r_pend_vld;
        o_cmd         = '0;
        o_cmd.out_sel = OSEL_ZERO;
        o_cmd.src_b   = (r_phase == PH_UB);
        o_lim_a       = '0;
        o_lim_b       = '0;
        o_idx         = r_idx;
        o_s_tready    = (r_state == ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    case (i_action)
                        ACT_APP_A: o_cmd.app_a = 1'b1;
                        ACT_APP_B: o_cmd.app_b = 1'b1;
                        ACT_RUN: begin
                            n_phase = PH_UA;
                            n_idx   = '0;
                            n_state = ST_NEXT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_NEXT: begin
                case (r_phase)
                    PH_UA: begin
                        if (r_idx < i_cnt_a) begin
                            n_state = ST_FETCH;
                        end else begin
                            n_phase = PH_UB;
                            n_idx   = '0;
                        end
                    end
                    PH_UB: begin
                        if (r_idx < i_cnt_b) begin
                            n_state = ST_FETCH;
                        end else if ((i_cnt_a == '0) && (i_cnt_b == '0)) begin
                            n_state = ST_UMARK;
                        end else begin
                            n_phase = PH_IN;
                            n_idx   = '0;
                        end
                    end
                    PH_IN: begin
                        if (r_idx < i_cnt_a) begin
                            n_state = ST_FETCH;
                        end else begin
                            n_state = ST_IFIN;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = ST_CAND;
            end
            ST_CAND: begin
                o_cmd.cand_ld    = 1'b1;
                o_cmd.scan_start = 1'b1;
                case (r_phase)
                    PH_UB: begin
                        o_lim_a = i_cnt_a;
                        o_lim_b = r_idx;
                    end
                    PH_IN: begin
                        o_lim_a = r_idx;
                        o_lim_b = i_cnt_b;
                    end
                    default: ;
                endcase
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    case (r_phase)
                        PH_UA: n_state = ST_EMIT;
                        PH_UB: begin
                            if (!i_sts.hit_a && !i_sts.hit_b) begin
                                n_state = ST_EMIT;
                            end else begin
                                n_idx   = r_idx + CW'(1);
                                n_state = ST_NEXT;
                            end
                        end
                        PH_IN: begin
                            if (i_sts.hit_b && !i_sts.hit_a) begin
                                if (r_pend_vld) begin
                                    n_state = ST_EMIT;
                                end else begin
                                    o_cmd.pend_ld = 1'b1;
                                    n_pend_vld    = 1'b1;
                                    n_idx         = r_idx + CW'(1);
                                    n_state       = ST_NEXT;
                                end
                            end else begin
                                n_idx   = r_idx + CW'(1);
                                n_state = ST_NEXT;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    if (r_phase == PH_IN) begin
                        o_cmd.out_sel  = OSEL_PEND;
                        o_cmd.out_kind = 1'b1;
                        o_cmd.pend_ld  = 1'b1;
                    end else begin
                        o_cmd.out_sel = OSEL_CAND;
                    end
                    n_idx   = r_idx + CW'(1);
                    n_state = ST_NEXT;
                end
            end
            ST_UMARK: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld    = 1'b1;
                    o_cmd.out_empty = 1'b1;
                    n_phase         = PH_IN;
                    n_idx           = '0;
                    n_state         = ST_NEXT;
                end
            end
            ST_IFIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = 1'b1;
                    o_cmd.out_last = 1'b1;
                    o_cmd.run_end  = 1'b1;
                    if (r_pend_vld) begin
                        o_cmd.out_sel = OSEL_PEND;
                    end else begin
                        o_cmd.out_empty = 1'b1;
                    end
                    n_pend_vld = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `SUI_ASSERT_SAME(a_pend_phase, r_pend_vld, r_phase == PH_IN, "held result outside intersection pass")
    `SUI_ASSERT_SAME(a_fetch_a_rng, (r_state == ST_FETCH) && (r_phase != PH_UB), r_idx < i_cnt_a, "fetch beyond list A")
    `SUI_ASSERT_SAME(a_fetch_b_rng, (r_state == ST_FETCH) && (r_phase == PH_UB), r_idx < i_cnt_b, "fetch beyond list B")

endmodule

### rtl/set_union_intersection.sv
// ============================================================================
// set_union_intersection
// Two value lists with a run command that streams their union, then their
// intersection.
// ============================================================================
//  channel  | dir | tdata          | tuser                        | tlast
//  s (in)   | in  | value          | action                       | -
//  m (out)  | out | item_value     | set_kind, set_empty, dropped | last
//
//  The block takes an item every cycle while idle.
//  A run checks each candidate against the stored lists one entry per cycle
//  through the single read port of each list memory, each scan running over
//  the longer list scanned. No input is taken during a run.
//  Reset is synchronous and clears counts, the overflow flag and the controller.
//  A stalled result holds in the output register; the run waits behind it.
// ============================================================================
module set_union_intersection import sui_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [VALUE_W-1:0]    i_s_tdata,  // value
    input  logic [ACTION_W-1:0]   i_s_tuser,  // action
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [VALUE_W-1:0]    o_m_tdata,  // item_value
    output logic [OUT_USER_W-1:0] o_m_tuser,  // set_kind, set_empty, dropped
    output logic                  o_m_tlast
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_cmd          cmd;
    t_sts          sts;
    logic [CW-1:0] cnt_a;
    logic [CW-1:0] cnt_b;
    logic [CW-1:0] idx;
    logic [CW-1:0] lim_a;
    logic [CW-1:0] lim_b;

    sui_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_action   (i_s_tuser),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd),
        .i_sts      (sts),
        .i_cnt_a    (cnt_a),
        .i_cnt_b    (cnt_b),
        .o_idx      (idx),
        .o_lim_a    (lim_a),
        .o_lim_b    (lim_b)
    );

    sui_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_idx      (idx),
        .i_lim_a    (lim_a),
        .i_lim_b    (lim_b),
        .i_value    (i_s_tdata),
        .o_sts      (sts),
        .o_cnt_a    (cnt_a),
        .o_cnt_b    (cnt_b),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
